// ===== hdl/ifrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt flag register block package
// Item layouts, operation codes, address map and a byte-insert helper.
// ----------------------------------------------------------------------------
package ifrb_pkg;

  localparam logic [15:0] FLAG_BASE      = 16'hFEB0;
  localparam int          RESET_HOLD_BIT = 5;

  localparam logic [15:0] ADDR_PRIO = 16'hFF18;
  localparam logic [15:0] ADDR_CTRL = 16'hFF19;
  localparam logic [15:0] ADDR_FALL = 16'hFF28;
  localparam logic [15:0] ADDR_RISE = 16'hFF29;

  localparam logic [3:0] OFF_STATUS_HI  = 4'h0;
  localparam logic [3:0] OFF_STATUS_LO  = 4'h1;
  localparam logic [3:0] OFF_RO_0       = 4'h2;
  localparam logic [3:0] OFF_RO_1       = 4'h3;
  localparam logic [3:0] OFF_RO_2       = 4'h4;
  localparam logic [3:0] OFF_RO_3       = 4'h5;
  localparam logic [3:0] OFF_CAPTURE_HI = 4'h6;
  localparam logic [3:0] OFF_CAPTURE_LO = 4'h7;
  localparam logic [3:0] OFF_ENABLE_HI  = 4'h8;
  localparam logic [3:0] OFF_ENABLE_LO  = 4'h9;
  localparam logic [3:0] OFF_OVF_HI     = 4'hA;
  localparam logic [3:0] OFF_OVF_LO     = 4'hB;
  localparam logic [3:0] OFF_COR_HI     = 4'hC;
  localparam logic [3:0] OFF_COR_LO     = 4'hD;
  localparam logic [3:0] OFF_EVENT_SEL  = 4'hF;

  localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;
  localparam logic [5:0] CTRL_RESET    = 6'h20;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_STATUS  = 2'd2,
    OP_CAPTURE = 2'd3
  } op_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic        level;
    logic [3:0]  line;
    logic [7:0]  wdata;
    logic [15:0] addr;
  } in_data_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic        reset_changed;
    logic        reset_held;
    logic [15:0] cleared_mask;
    logic [15:0] deliver;
    logic [7:0]  rdata;
  } out_data_t;

  function automatic logic [15:0] put_byte(input logic [15:0] reg_val, input logic hi,
                                           input logic [7:0] v);
    put_byte = hi ? {v, reg_val[7:0]} : {reg_val[15:8], v};
  endfunction

endpackage

// ===== hdl/interrupt_flag_register_block_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt flag register block core
// Byte-wide register window onto status, capture, enable and control flags.
// ----------------------------------------------------------------------------
// One item per clock, sustained: an item is held in the input register, then
// a single pass of logic updates the flag registers and loads the result
// register, from which the result is offered, and the input register takes
// the next item at the same edge that loads the result register.
// Only a stalled result output slows the input side. No clearing pass after
// reset.
module interrupt_flag_register_block_core
  import ifrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // addr[15:0], wdata[23:16], line[27:24], level[28]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // rdata[7:0], deliver[23:8], cleared_mask[39:24],
                                 // reset_held[40], reset_changed[41]
);

  logic        in_valid;
  op_t         in_op;
  in_data_t    in_item;
  out_data_t   res;
  logic        res_valid;
  logic        advance;

  logic [15:0] status_flags, capture_flags, enable_mask, overflow_enable, clear_on_read;
  logic [2:0]  event_select;
  logic [7:0]  priority_byte, falling_edge_sel, rising_edge_sel;
  logic [5:0]  control_byte;

  logic [15:0] status_flags_next, capture_flags_next, enable_mask_next;
  logic [15:0] overflow_enable_next, clear_on_read_next;
  logic [2:0]  event_select_next;
  logic [7:0]  priority_byte_next, falling_edge_sel_next, rising_edge_sel_next;
  logic [5:0]  control_byte_next;
  out_data_t   res_next;

  logic [15:0] off;
  logic        in_win;
  logic [15:0] line_bit;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = res_valid;
  assign m_tdata  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_op   <= op_t'(s_tuser);
      in_item <= in_data_t'(s_tdata);
    end
  end

  always_comb begin
    off      = in_item.addr - FLAG_BASE;
    in_win   = (in_item.addr >= FLAG_BASE) && (off[15:4] == 12'd0);
    line_bit = 16'd1 << in_item.line;

    status_flags_next     = status_flags;
    capture_flags_next    = capture_flags;
    enable_mask_next      = enable_mask;
    overflow_enable_next  = overflow_enable;
    clear_on_read_next    = clear_on_read;
    event_select_next     = event_select;
    priority_byte_next    = priority_byte;
    control_byte_next     = control_byte;
    falling_edge_sel_next = falling_edge_sel;
    rising_edge_sel_next  = rising_edge_sel;
    res_next              = '0;

    case (in_op)
      OP_READ: begin
        if (in_win) begin
          case (off[3:0])
            OFF_STATUS_HI:  res_next.rdata = status_flags[15:8];
            OFF_STATUS_LO:  res_next.rdata = status_flags[7:0];
            OFF_RO_0, OFF_RO_1, OFF_RO_2, OFF_RO_3: res_next.rdata = 8'd0;
            OFF_CAPTURE_HI: begin
              res_next.rdata     = capture_flags[15:8];
              capture_flags_next = capture_flags & ~(clear_on_read & 16'hFF00);
            end
            OFF_CAPTURE_LO: begin
              res_next.rdata     = capture_flags[7:0];
              capture_flags_next = capture_flags & ~(clear_on_read & 16'h00FF);
            end
            OFF_ENABLE_HI:  res_next.rdata = enable_mask[15:8];
            OFF_ENABLE_LO:  res_next.rdata = enable_mask[7:0];
            OFF_OVF_HI:     res_next.rdata = overflow_enable[15:8];
            OFF_OVF_LO:     res_next.rdata = overflow_enable[7:0];
            OFF_COR_HI:     res_next.rdata = clear_on_read[15:8];
            OFF_COR_LO:     res_next.rdata = clear_on_read[7:0];
            OFF_EVENT_SEL:  res_next.rdata = {5'd0, event_select};
            default:        res_next.rdata = UNMAPPED_BYTE;
          endcase
        end else if (in_item.addr == ADDR_PRIO) begin
          res_next.rdata = priority_byte;
        end else if (in_item.addr == ADDR_CTRL) begin
          res_next.rdata = {2'd0, control_byte};
        end else if (in_item.addr == ADDR_FALL) begin
          res_next.rdata = falling_edge_sel;
        end else if (in_item.addr == ADDR_RISE) begin
          res_next.rdata = rising_edge_sel;
        end else begin
          res_next.rdata = UNMAPPED_BYTE;
        end
      end
      OP_WRITE: begin
        if (in_win) begin
          case (off[3:0])
            OFF_STATUS_HI, OFF_STATUS_LO: begin
              status_flags_next = put_byte(status_flags, off[3:0] == OFF_STATUS_HI,
                                           in_item.wdata);
              res_next.cleared_mask = status_flags & ~status_flags_next;
            end
            OFF_CAPTURE_HI, OFF_CAPTURE_LO:
              capture_flags_next = put_byte(capture_flags, off[3:0] == OFF_CAPTURE_HI,
                                            in_item.wdata);
            OFF_ENABLE_HI, OFF_ENABLE_LO:
              enable_mask_next = put_byte(enable_mask, off[3:0] == OFF_ENABLE_HI,
                                          in_item.wdata);
            OFF_OVF_HI, OFF_OVF_LO:
              overflow_enable_next = put_byte(overflow_enable, off[3:0] == OFF_OVF_HI,
                                              in_item.wdata);
            OFF_COR_HI, OFF_COR_LO:
              clear_on_read_next = put_byte(clear_on_read, off[3:0] == OFF_COR_HI,
                                            in_item.wdata);
            OFF_EVENT_SEL:  event_select_next = in_item.wdata[2:0];
            default: ;
          endcase
        end else if (in_item.addr == ADDR_PRIO) begin
          priority_byte_next = in_item.wdata;
        end else if (in_item.addr == ADDR_CTRL) begin
          control_byte_next      = in_item.wdata[5:0];
          res_next.reset_changed = control_byte[RESET_HOLD_BIT] ^
                                   in_item.wdata[RESET_HOLD_BIT];
        end else if (in_item.addr == ADDR_FALL) begin
          falling_edge_sel_next = in_item.wdata;
        end else if (in_item.addr == ADDR_RISE) begin
          rising_edge_sel_next = in_item.wdata;
        end
      end
      OP_STATUS:
        status_flags_next = in_item.level ? (status_flags | line_bit)
                                          : (status_flags & ~line_bit);
      default:
        capture_flags_next = in_item.level ? (capture_flags | line_bit)
                                           : (capture_flags & ~line_bit);
    endcase

    res_next.deliver    = status_flags_next & enable_mask_next;
    res_next.reset_held = control_byte_next[RESET_HOLD_BIT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid        <= 1'b0;
      status_flags     <= '0;
      capture_flags    <= '0;
      enable_mask      <= '0;
      overflow_enable  <= '0;
      clear_on_read    <= '0;
      event_select     <= '0;
      priority_byte    <= '0;
      control_byte     <= CTRL_RESET;
      falling_edge_sel <= '0;
      rising_edge_sel  <= '0;
    end else begin
      if (advance) begin
        res_valid        <= 1'b1;
        status_flags     <= status_flags_next;
        capture_flags    <= capture_flags_next;
        enable_mask      <= enable_mask_next;
        overflow_enable  <= overflow_enable_next;
        clear_on_read    <= clear_on_read_next;
        event_select     <= event_select_next;
        priority_byte    <= priority_byte_next;
        control_byte     <= control_byte_next;
        falling_edge_sel <= falling_edge_sel_next;
        rising_edge_sel  <= rising_edge_sel_next;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
    if (advance) begin
      res <= res_next;
    end
  end

  a_changed_only_write: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.reset_changed) |-> (res.rdata == 8'd0 && res.cleared_mask == 16'd0))
    else $error("reset change reported on a result that is not a control write");

  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> (m_tvalid && res.reset_held == control_byte[RESET_HOLD_BIT] &&
                 res.deliver == (status_flags & enable_mask)))
    else $error("result register disagrees with flag registers");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stage empty but not ready");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt flag register block testbench
// Runs register reads and writes and flag line events through the stream
// ports. An in-bench copy of the flag, enable and control registers predicts
// each reply. Replies are checked field by field against the oldest
// prediction, while both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb;
  import ifrb_pkg::*;

  localparam int          LIMIT_NS = 2_000_000;
  localparam logic [3:0]  OFF_GAP  = 4'hE;

  typedef enum int {RX_FREE, RX_RANDOM, RX_EVERY_FOURTH, RX_SPARSE} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;

  // shadow copy of the block's registers
  logic [15:0] status_q   = '0;
  logic [15:0] capture_q  = '0;
  logic [15:0] enable_q   = '0;
  logic [15:0] ovf_en_q   = '0;
  logic [15:0] clr_read_q = '0;
  logic [2:0]  evsel_q    = '0;
  logic [7:0]  prio_q     = '0;
  logic [5:0]  ctrl_q     = CTRL_RESET;
  logic [7:0]  fall_q     = '0;
  logic [7:0]  rise_q     = '0;

  out_data_t pending_replies[$];
  int        mismatch_count = 0;
  int        holdoff_left   = 0;

  logic [15:0] fixed_addrs[4] = '{ADDR_PRIO, ADDR_CTRL, ADDR_FALL, ADDR_RISE};

  interrupt_flag_register_block_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] flag_addr(input logic [3:0] offs);
    return FLAG_BASE + {12'd0, offs};
  endfunction

  task automatic predict_access(input op_t op, input in_data_t d, output out_data_t r);
    logic [15:0] diff;
    logic [15:0] prev;
    logic [3:0]  offs;
    logic        in_window;
    logic        hold_before;
    r         = '0;
    diff      = d.addr - FLAG_BASE;
    offs      = diff[3:0];
    in_window = (d.addr >= FLAG_BASE) && (diff < 16'd16);
    case (op)
      OP_READ: begin
        if (in_window) begin
          case (offs)
            OFF_STATUS_HI:  r.rdata = status_q[15:8];
            OFF_STATUS_LO:  r.rdata = status_q[7:0];
            OFF_RO_0, OFF_RO_1, OFF_RO_2, OFF_RO_3: r.rdata = '0;
            OFF_CAPTURE_HI: begin
              r.rdata   = capture_q[15:8];
              capture_q = capture_q & ~(clr_read_q & 16'hFF00);
            end
            OFF_CAPTURE_LO: begin
              r.rdata   = capture_q[7:0];
              capture_q = capture_q & ~(clr_read_q & 16'h00FF);
            end
            OFF_ENABLE_HI:  r.rdata = enable_q[15:8];
            OFF_ENABLE_LO:  r.rdata = enable_q[7:0];
            OFF_OVF_HI:     r.rdata = ovf_en_q[15:8];
            OFF_OVF_LO:     r.rdata = ovf_en_q[7:0];
            OFF_COR_HI:     r.rdata = clr_read_q[15:8];
            OFF_COR_LO:     r.rdata = clr_read_q[7:0];
            OFF_EVENT_SEL:  r.rdata = {5'b0, evsel_q};
            default:        r.rdata = UNMAPPED_BYTE;
          endcase
        end else if (d.addr == ADDR_PRIO) begin
          r.rdata = prio_q;
        end else if (d.addr == ADDR_CTRL) begin
          r.rdata = {2'b0, ctrl_q};
        end else if (d.addr == ADDR_FALL) begin
          r.rdata = fall_q;
        end else if (d.addr == ADDR_RISE) begin
          r.rdata = rise_q;
        end else begin
          r.rdata = UNMAPPED_BYTE;
        end
      end
      OP_WRITE: begin
        if (in_window) begin
          case (offs)
            OFF_STATUS_HI, OFF_STATUS_LO: begin
              prev = status_q;
              if (offs == OFF_STATUS_HI) status_q[15:8] = d.wdata;
              else status_q[7:0] = d.wdata;
              r.cleared_mask = prev & ~status_q;
            end
            OFF_CAPTURE_HI: capture_q[15:8]  = d.wdata;
            OFF_CAPTURE_LO: capture_q[7:0]   = d.wdata;
            OFF_ENABLE_HI:  enable_q[15:8]   = d.wdata;
            OFF_ENABLE_LO:  enable_q[7:0]    = d.wdata;
            OFF_OVF_HI:     ovf_en_q[15:8]   = d.wdata;
            OFF_OVF_LO:     ovf_en_q[7:0]    = d.wdata;
            OFF_COR_HI:     clr_read_q[15:8] = d.wdata;
            OFF_COR_LO:     clr_read_q[7:0]  = d.wdata;
            OFF_EVENT_SEL:  evsel_q          = d.wdata[2:0];
            default: ;
          endcase
        end else if (d.addr == ADDR_PRIO) begin
          prio_q = d.wdata;
        end else if (d.addr == ADDR_CTRL) begin
          hold_before     = ctrl_q[RESET_HOLD_BIT];
          ctrl_q          = d.wdata[5:0];
          r.reset_changed = hold_before != ctrl_q[RESET_HOLD_BIT];
        end else if (d.addr == ADDR_FALL) begin
          fall_q = d.wdata;
        end else if (d.addr == ADDR_RISE) begin
          rise_q = d.wdata;
        end
      end
      OP_STATUS:  status_q[d.line]  = d.level;
      OP_CAPTURE: capture_q[d.line] = d.level;
      default: ;
    endcase
    r.deliver    = status_q & enable_q;
    r.reset_held = ctrl_q[RESET_HOLD_BIT];
  endtask

  task automatic post_access(input op_t op, input logic [15:0] addr, input logic [7:0] wdata,
                             input logic [3:0] line, input logic level);
    in_data_t  d;
    out_data_t r;
    d       = '0;
    d.addr  = addr;
    d.wdata = wdata;
    d.line  = line;
    d.level = level;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_access(op, d, r);
    pending_replies.push_back(r);
  endtask

  task automatic bus_rd(input logic [15:0] addr);
    post_access(OP_READ, addr, 8'h00, 4'h0, 1'b0);
  endtask

  task automatic bus_wr(input logic [15:0] addr, input logic [7:0] wdata);
    post_access(OP_WRITE, addr, wdata, 4'h0, 1'b0);
  endtask

  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      s_tuser  <= 2'($urandom);
    end
  endtask

  task automatic wait_for_replies();
    idle_sender(1);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_addr();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return FLAG_BASE + 16'($urandom_range(0, 15));
    if (sel < 72) return fixed_addrs[$urandom_range(0, 3)];
    if (sel < 78) return fixed_addrs[$urandom_range(0, 3)] + 16'd1 - 16'($urandom_range(0, 1) * 2);
    if (sel < 88) return FLAG_BASE - 16'd16 + 16'($urandom_range(0, 47));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_access();
    post_access(op_t'($urandom_range(0, 3)), pick_addr(), pick_byte(),
                4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_reset_state();
    bus_rd(flag_addr(OFF_STATUS_HI));
    bus_rd(flag_addr(OFF_RO_0));
    bus_rd(flag_addr(OFF_RO_3));
    bus_rd(flag_addr(OFF_CAPTURE_LO));
    bus_rd(flag_addr(OFF_EVENT_SEL));
    bus_rd(flag_addr(OFF_GAP));
    bus_rd(ADDR_CTRL);
    bus_rd(16'h0000);
    bus_rd(16'hFFFF);
  endtask

  task automatic test_control_and_narrow();
    bus_wr(ADDR_CTRL, 8'hFF);
    bus_wr(ADDR_CTRL, 8'h00);
    bus_rd(ADDR_CTRL);
    bus_wr(flag_addr(OFF_EVENT_SEL), 8'hFF);
    bus_rd(flag_addr(OFF_EVENT_SEL));
    bus_wr(flag_addr(OFF_RO_1), 8'hAA);
    bus_rd(flag_addr(OFF_RO_1));
  endtask

  task automatic test_flag_lines();
    bus_wr(flag_addr(OFF_ENABLE_HI), 8'hFF);
    bus_wr(flag_addr(OFF_ENABLE_LO), 8'h01);
    post_access(OP_STATUS, 16'h0000, 8'h00, 4'd15, 1'b1);
    post_access(OP_STATUS, 16'h0000, 8'h00, 4'd0, 1'b1);
    bus_wr(flag_addr(OFF_STATUS_HI), 8'h00);
    post_access(OP_CAPTURE, 16'h0000, 8'h00, 4'd15, 1'b1);
    post_access(OP_CAPTURE, 16'h0000, 8'h00, 4'd0, 1'b1);
    bus_wr(flag_addr(OFF_COR_LO), 8'hFF);
    bus_rd(flag_addr(OFF_CAPTURE_LO));
    bus_rd(flag_addr(OFF_CAPTURE_LO));
    bus_rd(flag_addr(OFF_CAPTURE_HI));
    post_access(OP_STATUS, 16'h0000, 8'h00, 4'd0, 1'b0);
  endtask

  task automatic test_random_traffic(input int count);
    int burst_left;
    burst_left = 0;
    repeat (count) begin
      if (burst_left == 0) begin
        idle_sender($urandom_range(0, 6));
        burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20);
      end
      burst_left--;
      send_random_access();
    end
  endtask

  task automatic test_backpressure();
    holdoff_left = 80;
    repeat (50) send_random_access();
  endtask

  task automatic test_quiet_pause();
    repeat (20) send_random_access();
    wait_for_replies();
    repeat (20) send_random_access();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_control_and_narrow();
    test_flag_lines();
    test_random_traffic(300);
    test_backpressure();
    test_quiet_pause();
    test_random_traffic(230);
    wait_for_replies();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       phase;
    mode      = RX_FREE;
    mode_left = 0;
    phase     = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_left > 0) begin
        m_tready <= 1'b0;
        holdoff_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_FREE:         m_tready <= 1'b1;
          RX_RANDOM:       m_tready <= ($urandom_range(0, 99) < 60);
          RX_EVERY_FOURTH: m_tready <= (phase % 4) != 3;
          default:         m_tready <= (phase % 7) < 2;
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] expv,
                             input logic [15:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_data_t got;
    out_data_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, m_tdata);
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("rdata", 16'(want.rdata), 16'(got.rdata));
        check_field("deliver", want.deliver, got.deliver);
        check_field("cleared_mask", want.cleared_mask, got.cleared_mask);
        check_field("reset_held", 16'(want.reset_held), 16'(got.reset_held));
        check_field("reset_changed", 16'(want.reset_changed), 16'(got.reset_changed));
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ifrb_pkg.sv
hdl/interrupt_flag_register_block_core.sv
sim/tb.sv
